### src/utt_pkg.sv
// Package for the UTF-16 to UTF-8 transcoder.
// Holds the status codes, the command record passed from front to back, and the byte encoder.
// No dependencies.
`default_nettype none

package utt_pkg;

  localparam int UTT_QUEUE_DEPTH = 4;

  localparam logic [15:0] OUT_LIMIT_RESET = 16'hFFFF;
  localparam logic [15:0] ONE_BYTE_LIMIT  = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIMIT  = 16'h0800;
  localparam logic [20:0] SUPP_BASE       = 21'h10000;
  localparam logic [5:0]  HIGH_SURR_TAG   = 6'b110110;
  localparam logic [5:0]  LOW_SURR_TAG    = 6'b110111;

  // UTF-8 form of U+FFFD.
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;
  localparam logic [2:0] REPL_LEN = 3'd3;

  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0,
    ST_NUL      = 2'd1,
    ST_ROOM     = 2'd2,
    ST_DANGLING = 2'd3
  } status_t;

  // Everything the back end needs to play out one transaction's bytes.
  typedef struct packed {
    logic [5:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            close;
    status_t         status;
    logic [15:0]     total;
  } utt_cmd_t;

  // Encodes a code point of the given UTF-8 length; byte 0 goes out first.
  function automatic logic [3:0][7:0] utt_encode(input logic [20:0] cp, input logic [2:0] len);
    logic [3:0][7:0] b;
    b = '0;
    case (len)
      3'd1: begin
        b[0] = cp[7:0];
      end
      3'd2: begin
        b[0] = {3'b110, cp[10:6]};
        b[1] = {2'b10, cp[5:0]};
      end
      3'd3: begin
        b[0] = {4'b1110, cp[15:12]};
        b[1] = {2'b10, cp[11:6]};
        b[2] = {2'b10, cp[5:0]};
      end
      3'd4: begin
        b[0] = {5'b11110, cp[20:18]};
        b[1] = {2'b10, cp[17:12]};
        b[2] = {2'b10, cp[11:6]};
        b[3] = {2'b10, cp[5:0]};
      end
      default: begin
        b = '0;
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### src/utt_if.sv
// Stream interfaces of the transcoder: code units in, UTF-8 bytes out.
// Plain valid/ready handshake; no dependencies.
`default_nettype none

interface utt_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, code_unit, last_unit, input ready);
  modport sink (input valid, code_unit, last_unit, output ready);
endinterface

interface utt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        run_last;
  logic        string_end;
  logic [1:0]  status;
  logic [15:0] bytes_written;

  modport source (output valid, out_byte, byte_valid, run_last, string_end, status,
                  bytes_written, input ready);
  modport sink (input valid, out_byte, byte_valid, run_last, string_end, status,
                bytes_written, output ready);
endinterface

`default_nettype wire

### src/utt_front.sv
// Front end: accepts code units, pairs surrogates, checks room and builds byte commands.
// Depends on utt_pkg and utt_in_if.
`default_nettype none

module utt_front
  import utt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  utt_in_if.sink        in_chan,
  input  wire logic [15:0] out_limit,
  input  wire logic     q_full,
  output logic          push,
  output utt_cmd_t      cmd
);

  logic        pending_valid;
  logic [9:0]  pending_high;
  logic [15:0] byte_count;
  logic        stopped;

  logic            accept;
  logic            is_hi, is_lo;
  logic [15:0]     cp_s;
  logic [2:0]      len_s;
  logic [15:0]     bc_s;
  logic            fit_s, fit_pair, fit_pre;
  logic [20:0]     cp_pair;
  logic [3:0][7:0] enc_s, enc_pair;
  logic [2:0]      nb;
  logic            room, nul, single, prefix;
  logic            pend_next;
  logic [9:0]      high_next;
  logic [5:0][7:0] bytes;
  logic [15:0]     bc_new;
  logic            close;
  status_t         reason;

  assign in_chan.ready = !q_full;
  assign accept = in_chan.valid && in_chan.ready;

  assign is_hi = in_chan.code_unit[15:10] == HIGH_SURR_TAG;
  assign is_lo = in_chan.code_unit[15:10] == LOW_SURR_TAG;
  assign cp_s  = is_lo ? 16'hFFFD : in_chan.code_unit;
  assign len_s = (cp_s < ONE_BYTE_LIMIT) ? 3'd1 : (cp_s < TWO_BYTE_LIMIT) ? 3'd2 : 3'd3;
  assign cp_pair = SUPP_BASE + {1'b0, pending_high, in_chan.code_unit[9:0]};

  // With a broken pair the unit itself is checked after the replacement's three bytes.
  assign bc_s     = pending_valid ? byte_count + 16'(REPL_LEN) : byte_count;
  assign fit_pair = ({1'b0, byte_count} + 17'd4) <= {1'b0, out_limit};
  assign fit_pre  = ({1'b0, byte_count} + 17'(REPL_LEN)) <= {1'b0, out_limit};
  assign fit_s    = ({1'b0, bc_s} + {14'b0, len_s}) <= {1'b0, out_limit};

  assign enc_s    = utt_encode({5'b0, cp_s}, len_s);
  assign enc_pair = utt_encode(cp_pair, 3'd4);

  always_comb begin
    nb        = 3'd0;
    room      = 1'b0;
    nul       = 1'b0;
    single    = 1'b0;
    prefix    = 1'b0;
    pend_next = 1'b0;
    high_next = pending_high;
    bytes     = '0;
    if (pending_valid && is_lo) begin
      if (fit_pair) begin
        nb         = 3'd4;
        bytes[3:0] = enc_pair;
      end else begin
        room = 1'b1;
      end
    end else if (pending_valid && !fit_pre) begin
      room = 1'b1;
    end else begin
      single = 1'b1;
      prefix = pending_valid;
    end

    if (single) begin
      if (prefix) begin
        bytes[0]   = REPL_B0;
        bytes[1]   = REPL_B1;
        bytes[2]   = REPL_B2;
        bytes[5:3] = enc_s[2:0];
        nb         = REPL_LEN;
      end else begin
        bytes[3:0] = enc_s;
      end
      if (is_hi) begin
        pend_next = 1'b1;
        high_next = in_chan.code_unit[9:0];
      end else if (!fit_s) begin
        room = 1'b1;
      end else begin
        nb  = nb + len_s;
        nul = in_chan.code_unit == 16'h0000;
      end
    end
  end

  assign bc_new = byte_count + {13'b0, nb};

  always_comb begin
    close  = 1'b1;
    reason = ST_COMPLETE;
    if (room) begin
      reason = ST_ROOM;
    end else if (nul) begin
      reason = ST_NUL;
    end else if (in_chan.last_unit) begin
      reason = pend_next ? ST_DANGLING : ST_COMPLETE;
    end else begin
      close = 1'b0;
    end
  end

  assign push = accept && !stopped && (nb != 3'd0 || close);

  always_comb begin
    cmd.bytes  = bytes;
    cmd.nbytes = nb;
    cmd.close  = close;
    cmd.status = reason;
    cmd.total  = bc_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
      pending_high  <= '0;
      byte_count    <= '0;
      stopped       <= 1'b0;
    end else if (accept) begin
      if (stopped || (close && in_chan.last_unit)) begin
        // A string whose end was already reported swallows units up to its last one.
        if (in_chan.last_unit) begin
          pending_valid <= 1'b0;
          pending_high  <= '0;
          byte_count    <= '0;
          stopped       <= 1'b0;
        end
      end else if (close) begin
        pending_valid <= 1'b0;
        pending_high  <= '0;
        byte_count    <= bc_new;
        stopped       <= 1'b1;
      end else begin
        pending_valid <= pend_next;
        pending_high  <= high_next;
        byte_count    <= bc_new;
      end
    end
  end

endmodule

`default_nettype wire

### src/utt_queue.sv
// Small command queue between the front and back ends of the transcoder.
// Depends on utt_pkg for the command record.
`default_nettype none

module utt_queue
  import utt_pkg::*;
#(
  parameter int DEPTH = UTT_QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire utt_cmd_t push_data,
  input  wire logic     pop,
  output logic          full,
  output logic          nonempty,
  output utt_cmd_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  utt_cmd_t         slots [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full     = count == CNT_FULL;
  assign nonempty = count != '0;
  assign head     = slots[rptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/utt_back.sv
// Back end: plays out one command as a run of result transactions, one byte per cycle while out_chan.ready is high.
// Depends on utt_pkg and utt_out_if.
`default_nettype none

module utt_back
  import utt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     q_nonempty,
  input  wire utt_cmd_t q_head,
  output logic          pop,
  utt_out_if.source     out_chan
);

  logic     busy;
  utt_cmd_t cur;
  logic [2:0] idx;
  logic     last_row, fire, load;

  // A command with no bytes still gives one row that carries the string end.
  assign last_row = (cur.nbytes == 3'd0) || (idx == cur.nbytes - 3'd1);
  assign fire     = out_chan.valid && out_chan.ready;
  assign load     = !busy || (fire && last_row);
  assign pop      = load && q_nonempty;

  assign out_chan.valid         = busy;
  assign out_chan.byte_valid    = cur.nbytes != 3'd0;
  assign out_chan.out_byte      = (cur.nbytes != 3'd0) ? cur.bytes[idx] : 8'h00;
  assign out_chan.run_last      = last_row;
  assign out_chan.string_end    = last_row && cur.close;
  assign out_chan.status        = (last_row && cur.close) ? cur.status : ST_COMPLETE;
  assign out_chan.bytes_written = (last_row && cur.close) ? cur.total : 16'h0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= q_nonempty;
      idx  <= '0;
    end else if (fire) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
  end

endmodule

`default_nettype wire

### src/utf16_to_utf8_transcoder_unit.sv
// Top level of the UTF-16 to UTF-8 transcoder: register port, front end, queue, back end.
// Depends on utt_pkg, utt_if, utt_front, utt_queue and utt_back.
//
//   Channel   Direction  Carries
//   in_chan   in         code_unit, last_unit
//   out_chan  out        out_byte, byte_valid, run_last, string_end, status, bytes_written
//   APB       in/out     out_limit at byte address 0
//
// The front end takes one code unit per cycle while the command queue has room.
// The back end sends one row per cycle while out_chan.ready is high; a unit gives one row per
// byte it produces (one to six; one closing row without bytes, none for a pending high half).
// A stalled output fills the queue of QUEUE_DEPTH commands before in_chan.ready drops.
// Reset is synchronous; it empties the queue and clears the string state.
`default_nettype none

module utf16_to_utf8_transcoder_unit
  import utt_pkg::*;
#(
  parameter int QUEUE_DEPTH = UTT_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  utt_in_if.sink           in_chan,
  utt_out_if.source        out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] out_limit;
  logic        q_full, q_nonempty, push, pop;
  utt_cmd_t    push_cmd, head_cmd;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'h0 : {16'h0, out_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= OUT_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      out_limit <= pwdata[15:0];
    end
  end

  utt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_chan   (in_chan),
    .out_limit (out_limit),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  utt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (head_cmd)
  );

  utt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (head_cmd),
    .pop        (pop),
    .out_chan   (out_chan)
  );

  // A row without a byte exists only to close a string.
  a_empty_row_closes: assert property (@(posedge clk) disable iff (rst)
    out_chan.valid && !out_chan.byte_valid |-> out_chan.string_end && out_chan.run_last)
    else $error("row without byte does not close the string");

  // The string end always falls on the last row of its transaction run.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_chan.valid && out_chan.string_end |-> out_chan.run_last)
    else $error("string end before the last row of the run");

  // A nonzero status is only reported together with the string end.
  a_status_at_end: assert property (@(posedge clk) disable iff (rst)
    out_chan.valid && out_chan.status != ST_COMPLETE |-> out_chan.string_end)
    else $error("status reported away from the string end");

  // The front end never pushes into a full queue because it is stalled then.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("command pushed into a full queue");

endmodule

`default_nettype wire
